FILE: rtl/dtlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtlf_pkg: shared definitions for the descriptor table
// Field widths, operation and status codes, controller command struct.
// ----------------------------------------------------------------------------
package dtlf_pkg;

  localparam int FUNC_W   = 3;
  localparam int FD_W     = 6;
  localparam int FILE_W   = 16;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_OPEN  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DUP   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DUP2  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the accepted input word
    logic commit;  // update the table and load the result register
  } dtlf_cmd_t;

endpackage

FILE: rtl/dtlf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtlf_in_if: request channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface dtlf_in_if;
  import dtlf_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [FD_W-1:0]   fd;
  logic [FD_W-1:0]   target_fd;
  logic [FILE_W-1:0] file_id;

  modport source (output valid, output func, output fd, output target_fd,
                  output file_id, input ready);
  modport sink   (input valid, input func, input fd, input target_fd,
                  input file_id, output ready);
endinterface

FILE: rtl/dtlf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtlf_out_if: response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface dtlf_out_if;
  import dtlf_pkg::*;

  logic                valid;
  logic                ready;
  logic [FD_W-1:0]     result_fd;
  logic [FILE_W-1:0]   result_file;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output result_fd, output result_file,
                  output status, input ready);
  modport sink   (input valid, input result_fd, input result_file,
                  input status, output ready);
endinterface

FILE: rtl/descriptor_table_lowest_free.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_table_lowest_free: descriptor table with lowest-free allocation
// Open, dup, dup2, close and query on a table of valid bits and file ids.
// ----------------------------------------------------------------------------
// Each request word passes through the states IDLE, READ and EXEC: IDLE
// to accept, READ to read the source entry of the file memory and register
// the first level of the lowest-free search, and EXEC to finish the search,
// write the table and load the result register. A new request is taken in
// the cycle after the result is loaded, so the block takes no new word until
// the last one is through EXEC; the result register holds a finished word
// while the next request is already accepted, and the execute cycle waits
// while that word is still untaken. Every request gives exactly one response
// word. The table starts empty after reset; no clearing pass is needed.
module descriptor_table_lowest_free #(
  parameter int NUM_DESCRIPTORS = 64,
  parameter int FILE_ID_BITS    = 16
) (
  input  logic      clk,
  input  logic      rst,
  dtlf_in_if.sink   req,
  dtlf_out_if.source rsp
);
  import dtlf_pkg::*;

  dtlf_cmd_t cmd;

  // Sequencer
  dtlf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Table and result datapath
  dtlf_datapath #(
    .NUM_DESCRIPTORS (NUM_DESCRIPTORS),
    .FILE_ID_BITS    (FILE_ID_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (req.func),
    .fd          (req.fd),
    .target_fd   (req.target_fd),
    .file_id     (req.file_id),
    .result_fd   (rsp.result_fd),
    .result_file (rsp.result_file),
    .status      (rsp.status)
  );

`ifndef ASSERT_OFF
  // An accepted word keeps the request side closed while it executes
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted during execution");

  // A new result appears only after the read and execute cycles
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(!req.ready, 1) && $past(!req.ready, 2)))
    else $error("result without read and execute cycles");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.status == ST_OK || rsp.status == ST_FULL ||
                   rsp.status == ST_BAD))
    else $error("undefined status code");

  // Failed operations return zero payload
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |->
      (rsp.result_fd == '0 && rsp.result_file == '0))
    else $error("nonzero payload on failed operation");
`endif

endmodule

FILE: rtl/dtlf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtlf_ctrl: operation sequencer
// Steps each word through read and execute, and owns the result valid flag.
// ----------------------------------------------------------------------------
module dtlf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output dtlf_pkg::dtlf_cmd_t cmd
);
  import dtlf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready   = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign cmd.load   = in_valid && (state == S_IDLE);
  assign cmd.commit = (state == S_EXEC) && out_free;

  // State and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (out_ready) out_valid <= 1'b0;
          if (in_valid) state <= S_READ;
        end
        S_READ: begin
          if (out_ready) out_valid <= 1'b0;
          state <= S_EXEC;
        end
        S_EXEC: begin
          // hold until the result register can take the new word
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/dtlf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtlf_datapath: descriptor table storage and operation logic
// Valid bits, file memory, two-level lowest-free search, result register.
// ----------------------------------------------------------------------------
module dtlf_datapath #(
  parameter int NUM_DESCRIPTORS = 64,
  parameter int FILE_ID_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dtlf_pkg::dtlf_cmd_t             cmd,
  input  logic [dtlf_pkg::FUNC_W-1:0]     func,
  input  logic [dtlf_pkg::FD_W-1:0]       fd,
  input  logic [dtlf_pkg::FD_W-1:0]       target_fd,
  input  logic [dtlf_pkg::FILE_W-1:0]     file_id,
  output logic [dtlf_pkg::FD_W-1:0]       result_fd,
  output logic [dtlf_pkg::FILE_W-1:0]     result_file,
  output logic [dtlf_pkg::STATUS_W-1:0]   status
);
  import dtlf_pkg::*;

  localparam int IDX_W      = $clog2(NUM_DESCRIPTORS);
  localparam int WIDE_W     = (IDX_W >= FD_W) ? IDX_W + 1 : FD_W + 1;
  localparam int NUM_GROUPS = (NUM_DESCRIPTORS + 7) / 8;
  localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int SLOT_W     = GRP_W + 3;
  localparam int FW_WIDE    = (FILE_ID_BITS > FILE_W) ? FILE_ID_BITS : FILE_W;

  // Latched input word
  logic [FUNC_W-1:0] func_q;
  logic [FD_W-1:0]   fd_q;
  logic [FD_W-1:0]   tfd_q;
  logic [FILE_W-1:0] fid_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      fd_q   <= fd;
      tfd_q  <= target_fd;
      fid_q  <= file_id;
    end
  end

  // Descriptor range checks and table indexes
  logic [WIDE_W-1:0] fd_wide;
  logic [WIDE_W-1:0] tfd_wide;
  logic [IDX_W-1:0]  fd_idx;
  logic [IDX_W-1:0]  tfd_idx;
  logic              fd_in;
  logic              tfd_in;

  assign fd_wide  = WIDE_W'(fd_q);
  assign tfd_wide = WIDE_W'(tfd_q);
  assign fd_idx   = fd_wide[IDX_W-1:0];
  assign tfd_idx  = tfd_wide[IDX_W-1:0];
  assign fd_in    = fd_wide < WIDE_W'(NUM_DESCRIPTORS);
  assign tfd_in   = tfd_wide < WIDE_W'(NUM_DESCRIPTORS);

  // File identifier memory, registered read at the source descriptor
  logic [FILE_ID_BITS-1:0] mem [NUM_DESCRIPTORS];
  logic [FILE_ID_BITS-1:0] rdata;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [FILE_ID_BITS-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    rdata <= mem[fd_idx];
    if (cmd.commit && mem_we) mem[mem_waddr] <= mem_wdata;
  end

  // Valid bits
  logic [NUM_DESCRIPTORS-1:0] valid;
  logic                       vwr_en;
  logic [IDX_W-1:0]           vwr_idx;
  logic                       vwr_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.commit && vwr_en) begin
      valid[vwr_idx] <= vwr_val;
    end
  end

  // Search stage one: lowest free entry in each group of eight, registered
  logic [NUM_GROUPS*8-1:0] pad;
  logic [NUM_GROUPS-1:0]   grp_free_c;
  logic [2:0]              grp_low_c [NUM_GROUPS];
  logic [NUM_GROUPS-1:0]   grp_free;
  logic [2:0]              grp_low [NUM_GROUPS];

  always_comb begin
    pad = '1;
    pad[NUM_DESCRIPTORS-1:0] = valid;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_free_c[g] = 1'b0;
      grp_low_c[g]  = 3'd0;
      for (int b = 7; b >= 0; b--) begin
        if (!pad[g*8+b]) begin
          grp_free_c[g] = 1'b1;
          grp_low_c[g]  = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_free <= grp_free_c;
    grp_low  <= grp_low_c;
  end

  // Search stage two: lowest group with a free entry
  logic             any_free;
  logic [GRP_W-1:0] sel_grp;
  logic [SLOT_W-1:0] slot_wide;
  logic [IDX_W-1:0] slot;

  always_comb begin
    any_free = 1'b0;
    sel_grp  = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        any_free = 1'b1;
        sel_grp  = GRP_W'(g);
      end
    end
  end

  assign slot_wide = {sel_grp, grp_low[sel_grp]};
  assign slot      = slot_wide[IDX_W-1:0];

  // Width conversions for file identifiers and the allocated slot
  logic [FW_WIDE-1:0]      fid_wide;
  logic [FILE_ID_BITS-1:0] fid_store;
  logic [FW_WIDE-1:0]      rdata_wide;
  logic [WIDE_W-1:0]       slot_out;
  logic                    live;

  assign fid_wide   = FW_WIDE'(fid_q);
  assign fid_store  = fid_wide[FILE_ID_BITS-1:0];
  assign rdata_wide = FW_WIDE'(rdata);
  assign slot_out   = WIDE_W'(slot);
  assign live       = fd_in && valid[fd_idx];

  // Operation decode
  logic [FD_W-1:0]     rfd_next;
  logic [FILE_W-1:0]   rfile_next;
  logic [STATUS_W-1:0] status_next;

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = slot;
    mem_wdata   = rdata;
    vwr_en      = 1'b0;
    vwr_idx     = slot;
    vwr_val     = 1'b1;
    rfd_next    = '0;
    rfile_next  = '0;
    status_next = ST_OK;
    unique case (func_q)
      FUNC_OPEN: begin
        if (any_free) begin
          mem_we    = 1'b1;
          mem_wdata = fid_store;
          vwr_en    = 1'b1;
          rfd_next  = slot_out[FD_W-1:0];
        end else begin
          status_next = ST_FULL;
        end
      end
      FUNC_DUP: begin
        if (!live) begin
          status_next = ST_BAD;
        end else if (any_free) begin
          mem_we   = 1'b1;
          vwr_en   = 1'b1;
          rfd_next = slot_out[FD_W-1:0];
        end else begin
          status_next = ST_FULL;
        end
      end
      FUNC_DUP2: begin
        if (!live || !tfd_in) begin
          status_next = ST_BAD;
        end else if (tfd_q != fd_q) begin
          mem_we    = 1'b1;
          mem_waddr = tfd_idx;
          vwr_en    = 1'b1;
          vwr_idx   = tfd_idx;
        end
      end
      FUNC_CLOSE: begin
        if (!fd_in) begin
          status_next = ST_BAD;
        end else begin
          vwr_en  = 1'b1;
          vwr_idx = fd_idx;
          vwr_val = 1'b0;
        end
      end
      FUNC_QUERY: begin
        if (!live) status_next = ST_BAD;
        else       rfile_next  = rdata_wide[FILE_W-1:0];
      end
      default: begin
        // unused codes leave the table alone and return zeros
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result_fd   <= rfd_next;
      result_file <= rfile_next;
      status      <= status_next;
    end
  end

endmodule

FILE: tb/descriptor_table_lowest_free_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_table_lowest_free_tb: self-checking bench for the descriptor table
// Runs a short table of hand-written words first. A typed-in response is
// given where it is obvious. Then bursts of random words follow: fill,
// mixed and drain bursts, so the table runs full and back to empty many
// times. A local copy of the table predicts every response, and the bench
// checks each response word against the oldest pending prediction. Both
// channels idle at random, except for one stretch that runs flat out.
// ----------------------------------------------------------------------------
module descriptor_table_lowest_free_tb;
  import dtlf_pkg::*;

  localparam int NUM_FD       = 64;
  localparam int RANDOM_WORDS = 900;
  localparam int IDLE_PCT     = 37;
  localparam int MAX_REPORTS  = 10;

  // Unused operation codes, expected to leave the table alone
  localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [FD_W-1:0]   fd;
    logic [FD_W-1:0]   target_fd;
    logic [FILE_W-1:0] file_id;
  } req_word_t;

  typedef struct packed {
    logic [FD_W-1:0]     result_fd;
    logic [FILE_W-1:0]   result_file;
    logic [STATUS_W-1:0] status;
  } rsp_word_t;

  typedef struct packed {
    req_word_t req;
    logic      typed;  // use rsp below instead of the table prediction
    rsp_word_t rsp;
  } dir_row_t;

  typedef enum logic [1:0] {BURST_FILL, BURST_MIX, BURST_DRAIN} burst_e;

  localparam int NUM_DIR = 26;

  // Hand-written opening sequence, starting from an empty table
  dir_row_t dir_rows [NUM_DIR] = '{
    '{'{FUNC_QUERY, 6'd0,  6'd0,  16'h0000}, 1'b1, '{6'd0, 16'h0000, ST_BAD}},
    '{'{FUNC_DUP,   6'd63, 6'd0,  16'h0000}, 1'b1, '{6'd0, 16'h0000, ST_BAD}},
    '{'{FUNC_DUP2,  6'd0,  6'd5,  16'h0000}, 1'b1, '{6'd0, 16'h0000, ST_BAD}},
    '{'{FUNC_CLOSE, 6'd63, 6'd0,  16'h0000}, 1'b1, '{6'd0, 16'h0000, ST_OK}},
    '{'{FUNC_OPEN,  6'd0,  6'd0,  16'h0000}, 1'b1, '{6'd0, 16'h0000, ST_OK}},
    '{'{FUNC_OPEN,  6'd63, 6'd63, 16'hFFFF}, 1'b1, '{6'd1, 16'h0000, ST_OK}},
    '{'{FUNC_QUERY, 6'd1,  6'd0,  16'h0000}, 1'b1, '{6'd0, 16'hFFFF, ST_OK}},
    '{'{FUNC_DUP,   6'd1,  6'd0,  16'h0000}, 1'b1, '{6'd2, 16'h0000, ST_OK}},
    '{'{FUNC_DUP2,  6'd1,  6'd63, 16'h0000}, 1'b1, '{6'd0, 16'h0000, ST_OK}},
    '{'{FUNC_QUERY, 6'd63, 6'd0,  16'h0000}, 1'b1, '{6'd0, 16'hFFFF, ST_OK}},
    '{'{FUNC_DUP2,  6'd0,  6'd0,  16'h1234}, 1'b1, '{6'd0, 16'h0000, ST_OK}},
    '{'{FUNC_QUERY, 6'd0,  6'd0,  16'h0000}, 1'b1, '{6'd0, 16'h0000, ST_OK}},
    '{'{FUNC_DUP2,  6'd0,  6'd1,  16'h0000}, 1'b1, '{6'd0, 16'h0000, ST_OK}},
    '{'{FUNC_QUERY, 6'd1,  6'd0,  16'h0000}, 1'b1, '{6'd0, 16'h0000, ST_OK}},
    '{'{FUNC_CLOSE, 6'd0,  6'd0,  16'h0000}, 1'b1, '{6'd0, 16'h0000, ST_OK}},
    '{'{FUNC_QUERY, 6'd0,  6'd0,  16'h0000}, 1'b1, '{6'd0, 16'h0000, ST_BAD}},
    '{'{FUNC_OPEN,  6'd0,  6'd0,  16'hA5A5}, 1'b1, '{6'd0, 16'h0000, ST_OK}},
    '{'{FUNC_DUP,   6'd63, 6'd0,  16'h0000}, 1'b1, '{6'd3, 16'h0000, ST_OK}},
    '{'{FUNC_DUP2,  6'd2,  6'd0,  16'h0000}, 1'b1, '{6'd0, 16'h0000, ST_OK}},
    '{'{FUNC_QUERY, 6'd0,  6'd0,  16'h0000}, 1'b1, '{6'd0, 16'hFFFF, ST_OK}},
    '{'{FUNC_RSVD5, 6'd63, 6'd63, 16'hFFFF}, 1'b1, '{6'd0, 16'h0000, ST_OK}},
    '{'{FUNC_RSVD6, 6'd42, 6'd21, 16'h5A5A}, 1'b1, '{6'd0, 16'h0000, ST_OK}},
    '{'{FUNC_RSVD7, 6'd3,  6'd0,  16'hFFFF}, 1'b1, '{6'd0, 16'h0000, ST_OK}},
    '{'{FUNC_CLOSE, 6'd63, 6'd0,  16'h0000}, 1'b1, '{6'd0, 16'h0000, ST_OK}},
    '{'{FUNC_DUP,   6'd63, 6'd0,  16'h0000}, 1'b1, '{6'd0, 16'h0000, ST_BAD}},
    '{'{FUNC_DUP2,  6'd3,  6'd40, 16'h0000}, 1'b0, '{6'd0, 16'h0000, ST_OK}}
  };

  logic clk;
  logic rst;
  logic calm;  // no idling on either side while set

  dtlf_in_if  req_if ();
  dtlf_out_if rsp_if ();

  descriptor_table_lowest_free u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Local copy of the table
  bit                fd_open [NUM_FD];
  logic [FILE_W-1:0] fd_file [NUM_FD];

  rsp_word_t pending_rsp [$];
  int        fail_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Lowest free descriptor, -1 when the table is full
  function automatic int lowest_free_fd();
    for (int i = 0; i < NUM_FD; i++) begin
      if (!fd_open[i]) return i;
    end
    return -1;
  endfunction

  function automatic int open_total();
    int n;
    n = 0;
    for (int i = 0; i < NUM_FD; i++) n += fd_open[i];
    return n;
  endfunction

  // Applies one word to the local table and returns its response
  function automatic rsp_word_t table_apply(req_word_t w);
    rsp_word_t r;
    int        slot;
    r    = '0;
    slot = lowest_free_fd();
    case (w.func)
      FUNC_OPEN: begin
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          fd_open[slot] = 1'b1;
          fd_file[slot] = w.file_id;
          r.result_fd   = FD_W'(slot);
        end
      end
      FUNC_DUP: begin
        // source is checked before room
        if (!fd_open[w.fd]) begin
          r.status = ST_BAD;
        end else if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          fd_open[slot] = 1'b1;
          fd_file[slot] = fd_file[w.fd];
          r.result_fd   = FD_W'(slot);
        end
      end
      FUNC_DUP2: begin
        if (!fd_open[w.fd]) begin
          r.status = ST_BAD;
        end else if (w.target_fd != w.fd) begin
          fd_file[w.target_fd] = fd_file[w.fd];
          fd_open[w.target_fd] = 1'b1;
        end
      end
      FUNC_CLOSE: fd_open[w.fd] = 1'b0;
      FUNC_QUERY: begin
        if (!fd_open[w.fd]) r.status = ST_BAD;
        else r.result_file = fd_file[w.fd];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random open descriptor, or a random one when none is open
  function automatic logic [FD_W-1:0] pick_open_fd();
    int start;
    start = $urandom_range(NUM_FD - 1);
    for (int i = 0; i < NUM_FD; i++) begin
      if (fd_open[(start + i) % NUM_FD]) return FD_W'((start + i) % NUM_FD);
    end
    return FD_W'(start);
  endfunction

  function automatic req_word_t make_word(burst_e mode);
    req_word_t w;
    int        roll;
    int        pick;
    roll = $urandom_range(99);
    if ($urandom_range(99) < 80) w.fd = pick_open_fd();
    else w.fd = FD_W'($urandom_range(NUM_FD - 1));
    if ($urandom_range(9) == 0) w.target_fd = w.fd;
    else w.target_fd = FD_W'($urandom_range(NUM_FD - 1));
    pick = $urandom_range(19);
    if (pick == 0) w.file_id = '0;
    else if (pick == 1) w.file_id = '1;
    else w.file_id = FILE_W'($urandom);
    // reserved codes a few percent of the time in every burst
    w.func = FUNC_RSVD5 + FUNC_W'($urandom_range(2));
    case (mode)
      BURST_FILL: begin
        if (roll < 50) w.func = FUNC_OPEN;
        else if (roll < 80) w.func = FUNC_DUP;
        else if (roll < 88) w.func = FUNC_QUERY;
        else if (roll < 94) w.func = FUNC_DUP2;
        else if (roll < 97) w.func = FUNC_CLOSE;
      end
      BURST_MIX: begin
        if (roll < 20) w.func = FUNC_OPEN;
        else if (roll < 35) w.func = FUNC_DUP;
        else if (roll < 55) w.func = FUNC_DUP2;
        else if (roll < 75) w.func = FUNC_CLOSE;
        else if (roll < 95) w.func = FUNC_QUERY;
      end
      default: begin
        if (roll < 55) w.func = FUNC_CLOSE;
        else if (roll < 70) w.func = FUNC_QUERY;
        else if (roll < 85) w.func = FUNC_DUP2;
        else if (roll < 90) w.func = FUNC_OPEN;
        else if (roll < 95) w.func = FUNC_DUP;
      end
    endcase
    return w;
  endfunction

  // Drives one word, with an optional gap first; returns once accepted
  task automatic send_word(req_word_t w);
    int gap;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.func      <= w.func;
    req_if.fd        <= w.fd;
    req_if.target_fd <= w.target_fd;
    req_if.file_id   <= w.file_id;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic note_fail(string what, rsp_word_t want, rsp_word_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t %s: fd exp %0d got %0d, file exp %h got %h, status exp %0d got %0d",
               $time, what, want.result_fd, got.result_fd, want.result_file,
               got.result_file, want.status, got.status);
    end
  endtask

  // Response check and random backpressure
  always @(posedge clk) begin
    rsp_word_t got;
    rsp_word_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.result_fd, rsp_if.result_file, rsp_if.status};
      if (pending_rsp.size() == 0) begin
        note_fail("response with nothing pending", '0, got);
      end else begin
        want = pending_rsp.pop_front();
        if (got.result_fd !== want.result_fd || got.result_file !== want.result_file ||
            got.status !== want.status) begin
          note_fail("response mismatch", want, got);
        end
      end
    end
    rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Stimulus
  initial begin
    req_word_t w;
    rsp_word_t want;
    burst_e    mode;
    int        burst_left;

    fail_count       = 0;
    rst              <= 1'b1;
    calm             <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.func      <= FUNC_OPEN;
    req_if.fd        <= '0;
    req_if.target_fd <= '0;
    req_if.file_id   <= '0;
    for (int i = 0; i < NUM_FD; i++) begin
      fd_open[i] = 1'b0;
      fd_file[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].req);
      want = table_apply(dir_rows[i].req);
      if (dir_rows[i].typed) want = dir_rows[i].rsp;
      pending_rsp = {pending_rsp, want};
    end

    // Random bursts; the first one fills the table up
    mode       = BURST_FILL;
    burst_left = $urandom_range(80, 120);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (burst_left == 0) begin
        if (open_total() >= NUM_FD - 8) mode = ($urandom_range(1) == 0) ? BURST_DRAIN : BURST_MIX;
        else if (open_total() < 8) mode = BURST_FILL;
        else mode = burst_e'($urandom_range(2));
        burst_left = $urandom_range(30, 120);
      end
      burst_left--;
      calm <= (i >= 350 && i < 500);
      w = make_word(mode);
      send_word(w);
      want = table_apply(w);
      pending_rsp = {pending_rsp, want};
    end
    req_if.valid <= 1'b0;
    calm         <= 1'b0;

    // Drain the responses, then wait quietly before the verdict
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dtlf_pkg.sv
rtl/dtlf_in_if.sv
rtl/dtlf_out_if.sv
rtl/dtlf_ctrl.sv
rtl/dtlf_datapath.sv
rtl/descriptor_table_lowest_free.sv
tb/descriptor_table_lowest_free_tb.sv
